// ===== hw/rtl/tide_table_linear_interp_unit_assert.svh =====
// assertion macros for the tide table interpolation unit
`ifndef TIDE_TABLE_LINEAR_INTERP_UNIT_ASSERT_SVH
`define TIDE_TABLE_LINEAR_INTERP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TTLI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttli same-cycle check failed");

// next-cycle implication
`define TTLI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttli next-cycle check failed");

`endif

// ===== hw/rtl/ttli_pkg.sv =====
// shared types and constants of the tide table interpolation unit
package ttli_pkg;

  localparam int TIME_W     = 44;
  localparam int LEVEL_W    = 16;
  localparam int IDX_W      = 10;
  localparam int DELTA_W    = 32;
  localparam int SCALE_W    = 16;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // blend datapath: accumulator, divider dividend and divisor
  localparam int ACC_W = 62;
  localparam int DVD_W = 61;
  localparam int DVS_W = 45;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_SHIFT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SCALE = 8'd1;

  localparam logic [SCALE_W-1:0] Q15_ONE = 16'd32768;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_INTERP = 2'd1,
    CMD_READ   = 2'd2,
    CMD_OFFSET = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_FEW       = 3'd2,
    STS_RANGE     = 3'd3,
    STS_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_MUL, S_INS_WR, S_INT_CHK0, S_INT_CHK1, S_SRCH, S_SRCH_CMP,
    S_PAIR_R, S_PAIR_C, S_MUL_LD, S_MUL, S_DIV_PREP, S_DIV_START, S_DIV_WAIT,
    S_RP_CAP, S_OFS_CHK, S_OFS_MUL, S_OFS_WR, S_DONE
  } fsm_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [TIME_W-1:0]          time_ms;
    logic signed [LEVEL_W-1:0]  level_mm;
    logic [IDX_W-1:0]           point_index;
    logic signed [DELTA_W-1:0]  delta_ms;
    logic [SCALE_W-1:0]         bulk_scale_q15;
  } in_data_t;

  typedef struct packed {
    status_t                    status;
    logic [TIME_W-1:0]          time_out_ms;
    logic signed [LEVEL_W-1:0]  level_out_mm;
    logic [COUNT_W-1:0]         point_count;
  } out_data_t;

endpackage

// ===== hw/rtl/ttli_div.sv =====
// restoring divider, one quotient bit per cycle
module ttli_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ttli_pkg::DVD_W-1:0] dividend,
  input  logic [ttli_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [ttli_pkg::DVD_W-1:0] quotient
);
  import ttli_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r, done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_r};
    if (!diff[DVS_W+1]) begin
      rem_nxt = diff[DVS_W-1:0];
    end else begin
      rem_nxt = trial[DVS_W-1:0];
    end
    quo_nxt = {quo_r[DVD_W-2:0], ~diff[DVS_W+1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/tide_table_linear_interp_unit.sv =====
// top level: tide table with binary search and linear interpolation
// one command at a time; offset rewrites every stored point, interpolate runs a binary search
// interpolate pace is set by two shift-add passes and a serial divider
// result shows for one cycle on out_valid and cannot be stalled
// rst_n is synchronous: clears point count, config registers to reset values, sequencer idle
// table memory is not cleared; entries are only read below the point count
module tide_table_linear_interp_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ttli_pkg::in_data_t              in_data,
  output logic                            out_valid,
  output ttli_pkg::out_data_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ttli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttli_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ttli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer
  fsm_t state_r, state_nxt;

  // control state
  logic [CW-1:0]              fill_r;
  logic signed [DELTA_W-1:0]  shift_r;
  logic [SCALE_W-1:0]         scale_r;

  // latched command and result
  in_data_t                   req_r;
  status_t                    res_status_r;
  logic [TIME_W-1:0]          res_time_r;
  logic signed [LEVEL_W-1:0]  res_level_r;

  // search and sweep pointers
  logic [AW-1:0]              lo_r, hi_r, mid;
  logic [CW-1:0]              ptr_r;

  // bracketing pair
  logic [TIME_W-1:0]          tl_r, tr_r;
  logic signed [LEVEL_W-1:0]  ll_r, lr_r;

  // scale path
  logic [TIME_W-1:0]          tsum_r;
  logic signed [32:0]         prod_r;
  logic [SCALE_W-1:0]         bulk;

  // serial multiply-accumulate
  logic signed [ACC_W-1:0]    ma_r, acc_r;
  logic [LEVEL_W-1:0]         mb_r;
  logic [3:0]                 mcnt_r;
  logic                       phase_r;

  // divide setup
  logic [DVS_W-1:0]           dabs_r;
  logic signed [ACC_W-1:0]    num_r;
  logic                       neg_r;
  logic signed [DVS_W-1:0]    dlt;
  logic [ACC_W-1:0]           num_abs;
  logic [DVD_W-1:0]           dividend;
  logic                       div_start, div_done;
  logic [DVD_W-1:0]           quotient;

  // table memory
  logic [TIME_W-1:0]          time_mem [TABLE_DEPTH];
  logic [LEVEL_W-1:0]         level_mem [TABLE_DEPTH];
  logic [AW-1:0]              rd_addr, wr_addr;
  logic                       wr_en;
  logic [TIME_W-1:0]          rd_t_r;
  logic signed [LEVEL_W-1:0]  rd_l_r;
  logic [LEVEL_W-1:0]         wr_level;

  logic                       idx_ok;

  // add a signed offset to a time, clamp to the 44 bit range
  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] t,
                                                 input logic signed [DELTA_W-1:0] d);
    logic signed [TIME_W+1:0] s;
    s = $signed({2'b00, t}) + (TIME_W+2)'(d);
    if (s < 0) begin
      sat_time = '0;
    end else if (s[TIME_W+1:TIME_W] != 2'b00) begin
      sat_time = '1;
    end else begin
      sat_time = s[TIME_W-1:0];
    end
  endfunction

  // q1.15 product to level: round half up, clamp to 16 bit
  function automatic logic [LEVEL_W-1:0] round_scale(input logic signed [32:0] p);
    logic signed [33:0] x;
    logic signed [18:0] r;
    x = 34'(p) + 34'sd16384;
    r = 19'(x >>> 15);
    if (r < -19'sd32768) begin
      round_scale = 16'h8000;
    end else if (r > 19'sd32767) begin
      round_scale = 16'h7fff;
    end else begin
      round_scale = r[LEVEL_W-1:0];
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign bulk      = (req_r.bulk_scale_q15 > Q15_ONE) ? Q15_ONE : req_r.bulk_scale_q15;
  assign mid       = AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign idx_ok    = 32'(in_data.point_index) < 32'(fill_r);
  assign wr_level  = round_scale(prod_r);
  assign num_abs   = num_r[ACC_W-1] ? ACC_W'(-num_r) : ACC_W'(num_r);
  assign dividend  = DVD_W'(num_abs) + DVD_W'(dabs_r >> 1);
  assign dlt       = $signed({1'b0, tr_r}) - $signed({1'b0, tl_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.cmd)
            CMD_INSERT: state_nxt = (fill_r == CW'(TABLE_DEPTH)) ? S_DONE : S_INS_MUL;
            CMD_INTERP: state_nxt = (fill_r < CW'(2)) ? S_DONE : S_INT_CHK0;
            CMD_READ:   state_nxt = idx_ok ? S_RP_CAP : S_DONE;
            default:    state_nxt = S_OFS_CHK;
          endcase
        end
      end
      S_INS_MUL:   state_nxt = S_INS_WR;
      S_INS_WR:    state_nxt = S_DONE;
      S_INT_CHK0:  state_nxt = (req_r.time_ms < rd_t_r) ? S_DONE : S_INT_CHK1;
      S_INT_CHK1:  state_nxt = (req_r.time_ms > rd_t_r) ? S_DONE : S_SRCH;
      S_SRCH:      state_nxt = (hi_r - lo_r > AW'(1)) ? S_SRCH_CMP : S_PAIR_R;
      S_SRCH_CMP:  state_nxt = S_SRCH;
      S_PAIR_R:    state_nxt = S_PAIR_C;
      S_PAIR_C:    state_nxt = (rd_t_r == tl_r) ? S_DONE : S_MUL_LD;
      S_MUL_LD:    state_nxt = S_MUL;
      S_MUL: begin
        if (mcnt_r == 4'd15) begin
          state_nxt = phase_r ? S_DIV_PREP : S_MUL_LD;
        end
      end
      S_DIV_PREP:  state_nxt = S_DIV_START;
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT:  state_nxt = div_done ? S_DONE : S_DIV_WAIT;
      S_RP_CAP:    state_nxt = S_DONE;
      S_OFS_CHK:   state_nxt = (ptr_r == fill_r) ? S_DONE : S_OFS_MUL;
      S_OFS_MUL:   state_nxt = S_OFS_WR;
      S_OFS_WR:    state_nxt = S_OFS_CHK;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: memory port control, handshake, divider kick
  always_comb begin
    rd_addr   = '0;
    wr_addr   = '0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    case (state_r)
      S_IDLE: begin
        // first entry for the lower bound check, or the point to read
        if (in_data.cmd == CMD_READ) begin
          rd_addr = AW'(in_data.point_index);
        end
      end
      S_INT_CHK0: rd_addr = AW'(fill_r - 1'b1);
      S_SRCH:     rd_addr = (hi_r - lo_r > AW'(1)) ? mid : lo_r;
      S_PAIR_R:   rd_addr = hi_r;
      S_OFS_CHK:  rd_addr = ptr_r[AW-1:0];
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = fill_r[AW-1:0];
      end
      S_OFS_WR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
      end
      S_DIV_START: div_start = 1'b1;
      default: ;
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= tsum_r;
      level_mem[wr_addr] <= wr_level;
    end
    rd_t_r <= time_mem[rd_addr];
    rd_l_r <= $signed(level_mem[rd_addr]);
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      shift_r <= '0;
      scale_r <= Q15_ONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INS_WR) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIME_SHIFT: shift_r <= $signed(cfg_data);
          REG_LEVEL_SCALE: begin
            // out-of-range scale writes are dropped
            if (cfg_data[SCALE_W-1:0] != '0 && cfg_data[SCALE_W-1:0] <= Q15_ONE) begin
              scale_r <= cfg_data[SCALE_W-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_r        <= in_data;
          res_status_r <= STS_OK;
          res_time_r   <= '0;
          res_level_r  <= '0;
          ptr_r        <= '0;
          phase_r      <= 1'b0;
          case (in_data.cmd)
            CMD_INSERT: begin
              if (fill_r == CW'(TABLE_DEPTH)) res_status_r <= STS_FULL;
            end
            CMD_INTERP: begin
              if (fill_r < CW'(2)) res_status_r <= STS_FEW;
            end
            CMD_READ: begin
              if (!idx_ok) res_status_r <= STS_BAD_INDEX;
            end
            default: ;
          endcase
        end
      end
      S_INS_MUL: begin
        tsum_r <= sat_time(req_r.time_ms, shift_r);
        prod_r <= req_r.level_mm * $signed({1'b0, scale_r});
      end
      S_INT_CHK0: begin
        if (req_r.time_ms < rd_t_r) res_status_r <= STS_RANGE;
      end
      S_INT_CHK1: begin
        if (req_r.time_ms > rd_t_r) res_status_r <= STS_RANGE;
        lo_r <= '0;
        hi_r <= AW'(fill_r - 1'b1);
      end
      S_SRCH_CMP: begin
        if (rd_t_r <= req_r.time_ms) begin
          lo_r <= mid;
        end else begin
          hi_r <= mid;
        end
      end
      S_PAIR_R: begin
        tl_r <= rd_t_r;
        ll_r <= rd_l_r;
      end
      S_PAIR_C: begin
        tr_r  <= rd_t_r;
        lr_r  <= rd_l_r;
        acc_r <= '0;
        // equal times give the left level
        if (rd_t_r == tl_r) res_level_r <= ll_r;
      end
      S_MUL_LD: begin
        // first pass ll * (tr - q), second pass lr * (q - tl)
        if (phase_r) begin
          ma_r <= ACC_W'($signed({1'b0, req_r.time_ms}) - $signed({1'b0, tl_r}));
          mb_r <= lr_r;
        end else begin
          ma_r <= ACC_W'($signed({1'b0, tr_r}) - $signed({1'b0, req_r.time_ms}));
          mb_r <= ll_r;
        end
        mcnt_r <= '0;
      end
      S_MUL: begin
        // sign bit of the level carries negative weight
        if (mb_r[0]) begin
          acc_r <= (mcnt_r == 4'd15) ? acc_r - ma_r : acc_r + ma_r;
        end
        ma_r   <= ma_r <<< 1;
        mb_r   <= mb_r >> 1;
        mcnt_r <= mcnt_r + 1'b1;
        if (mcnt_r == 4'd15) phase_r <= 1'b1;
      end
      S_DIV_PREP: begin
        // fold the sign of the time span into the numerator
        if (dlt < 0) begin
          dabs_r <= DVS_W'(-dlt);
          num_r  <= -acc_r;
        end else begin
          dabs_r <= DVS_W'(dlt);
          num_r  <= acc_r;
        end
      end
      S_DIV_START: neg_r <= num_r[ACC_W-1];
      S_DIV_WAIT: begin
        if (div_done) begin
          // round half away from zero, then clamp
          if (neg_r) begin
            res_level_r <= (quotient > DVD_W'(32768)) ? -16'sd32768
                                                       : LEVEL_W'(-quotient);
          end else begin
            res_level_r <= (quotient > DVD_W'(32767)) ? 16'sd32767
                                                       : LEVEL_W'(quotient);
          end
        end
      end
      S_RP_CAP: begin
        res_time_r  <= rd_t_r;
        res_level_r <= rd_l_r;
      end
      S_OFS_MUL: begin
        tsum_r <= sat_time(rd_t_r, req_r.delta_ms);
        prod_r <= rd_l_r * $signed({1'b0, bulk});
      end
      S_OFS_WR: ptr_r <= ptr_r + 1'b1;
      default: ;
    endcase
  end

  ttli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dabs_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    out_data.status       = res_status_r;
    out_data.time_out_ms  = res_time_r;
    out_data.level_out_mm = res_level_r;
    out_data.point_count  = COUNT_W'(fill_r);
  end

  `include "tide_table_linear_interp_unit_assert.svh"

  // a result beat is only shown while a command is in flight
  `TTLI_ASSERT_IMP(a_out_busy, out_valid, busy)
  // result strobe lasts exactly one cycle
  `TTLI_ASSERT_NXT(a_out_pulse, out_valid, !out_valid)
  // an accepted command always holds the block busy next cycle
  `TTLI_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // point count never passes the table depth
  `TTLI_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CW'(TABLE_DEPTH))

endmodule
